@@ hdl/ptw_pkg.sv @@
// Shared types and constants for the four-level page table walker.
// No dependencies; used by ptw_ctrl, ptw_dp and four_level_page_table_walker.
package ptw_pkg;

   // Geometry of one table and of an entry
   localparam int unsigned IDX_W      = 9;
   localparam int unsigned ENTRIES    = 512;
   localparam int unsigned ENTRY_W    = 52;
   localparam int unsigned PAGE_W     = 40;
   localparam int unsigned OFFSET_W   = 12;
   localparam int unsigned VPN_W      = 36;
   localparam logic [OFFSET_W-1:0] LINK_FLAGS_DEFAULT = 12'h007;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_MAP   = 2'd0,
      OP_UNMAP = 2'd1,
      OP_XLATE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Response status codes
   typedef enum logic [1:0] {
      RSP_DONE       = 2'd0,
      RSP_ABSENT     = 2'd1,
      RSP_POOL_EMPTY = 2'd2
   } status_type;

   // Request word
   typedef struct packed {
      logic [1:0]  op;
      logic [47:0] virt_addr;
      logic [51:0] page_addr;
      logic [11:0] flags;
   } req_type;

   // Response word
   typedef struct packed {
      logic [51:0] result_addr;
      logic [1:0]  status;
   } rsp_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_EVAL,
      S_FINISH
   } state_type;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic       clear_step;
      logic       accept;
      logic       link_new;
      logic       link_follow;
      logic       leaf_write;
      logic       set_res;
      status_type res_status;
      logic       res_from_entry;
      logic       emit;
   } cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic clear_last;
      logic in_op_none;
      logic op_xlate;
      logic level_last;
      logic entry_present;
      logic link_bad;
      logic pool_empty;
      logic rsp_free;
   } sts_type;

endpackage

@@ hdl/ptw_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ptw_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/ptw_ctrl.sv @@
// Walk sequencer: state machine that drives the datapath by commands.
// Depends on ptw_pkg.
module ptw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ptw_pkg::sts_type  sts,
   output ptw_pkg::cmd_type  cmd
);

   ptw_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptw_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptw_pkg::S_CLEAR: begin
            if (sts.clear_last) state_in = ptw_pkg::S_IDLE;
         end
         ptw_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = sts.in_op_none ? ptw_pkg::S_FINISH : ptw_pkg::S_LOOKUP;
            end
         end
         ptw_pkg::S_LOOKUP: begin
            // map and unmap write the leaf without reading it
            if (sts.level_last && !sts.op_xlate) state_in = ptw_pkg::S_FINISH;
            else                                 state_in = ptw_pkg::S_EVAL;
         end
         ptw_pkg::S_EVAL: begin
            priority if (sts.level_last)                         state_in = ptw_pkg::S_FINISH;
            else if (sts.entry_present && sts.link_bad)          state_in = ptw_pkg::S_FINISH;
            else if (!sts.entry_present && sts.pool_empty)       state_in = ptw_pkg::S_FINISH;
            else                                                 state_in = ptw_pkg::S_LOOKUP;
         end
         ptw_pkg::S_FINISH: begin
            if (sts.rsp_free) state_in = ptw_pkg::S_IDLE;
         end
         default: state_in = ptw_pkg::S_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      cmd.clear_step     = 1'b0;
      cmd.accept         = 1'b0;
      cmd.link_new       = 1'b0;
      cmd.link_follow    = 1'b0;
      cmd.leaf_write     = 1'b0;
      cmd.set_res        = 1'b0;
      cmd.res_status     = ptw_pkg::RSP_DONE;
      cmd.res_from_entry = 1'b0;
      cmd.emit           = 1'b0;
      req_stall          = 1'b1;
      unique case (state_ff)
         ptw_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ptw_pkg::S_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            // unused op answers at once
            cmd.set_res = req_valid && sts.in_op_none;
         end
         ptw_pkg::S_LOOKUP: begin
            if (sts.level_last && !sts.op_xlate) begin
               cmd.leaf_write = 1'b1;
               cmd.set_res    = 1'b1;
            end
         end
         ptw_pkg::S_EVAL: begin
            priority if (sts.level_last) begin
               cmd.set_res        = 1'b1;
               cmd.res_from_entry = sts.entry_present;
               cmd.res_status     = sts.entry_present ? ptw_pkg::RSP_DONE
                                                      : ptw_pkg::RSP_ABSENT;
            end else if (sts.entry_present) begin
               if (sts.link_bad) begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ptw_pkg::RSP_POOL_EMPTY;
               end else begin
                  cmd.link_follow = 1'b1;
               end
            end else begin
               if (sts.pool_empty) begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ptw_pkg::RSP_POOL_EMPTY;
               end else begin
                  cmd.link_new = 1'b1;
               end
            end
         end
         ptw_pkg::S_FINISH: begin
            cmd.emit = sts.rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

@@ hdl/ptw_dp.sv @@
// Walk datapath: request registers, frame allocator, table RAM and response register.
// Depends on ptw_pkg and ptw_ram.
module ptw_dp #(
   parameter int POOL_FRAMES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  ptw_pkg::req_type  req_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [51:0]       csr_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptw_pkg::rsp_type  rsp_data,
   input  ptw_pkg::cmd_type  cmd,
   output ptw_pkg::sts_type  sts
);

   localparam int FW    = $clog2(POOL_FRAMES);
   localparam int NW    = $clog2(POOL_FRAMES + 1);
   localparam int DEPTH = POOL_FRAMES * ptw_pkg::ENTRIES;
   localparam int AW    = FW + ptw_pkg::IDX_W;

   // Request and walk registers
   logic [1:0]                      op_ff;
   logic [ptw_pkg::VPN_W-1:0]       vpn_ff;
   logic [ptw_pkg::ENTRY_W-1:0]     pa_ff;
   logic [ptw_pkg::OFFSET_W-1:0]    fl_ff;
   logic [FW-1:0]                   frame_ff;
   logic [1:0]                      level_ff;
   logic [NW-1:0]                   next_free_ff;
   logic [AW-1:0]                   clr_ff;
   logic [ptw_pkg::PAGE_W-1:0]      base_ff;
   logic [ptw_pkg::ENTRY_W-1:0]     res_addr_ff;
   ptw_pkg::status_type             res_status_ff;
   logic                            rsp_valid_ff;
   ptw_pkg::rsp_type                rsp_data_ff;

   logic [ptw_pkg::IDX_W-1:0]       idx;
   logic [AW-1:0]                   walk_addr;
   logic [ptw_pkg::ENTRY_W-1:0]     rd_entry;
   logic [ptw_pkg::PAGE_W-1:0]      child_off;
   logic [ptw_pkg::OFFSET_W-1:0]    link_flags;
   logic [ptw_pkg::ENTRY_W-1:0]     link_value;
   logic [ptw_pkg::ENTRY_W-1:0]     leaf_value;
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [ptw_pkg::ENTRY_W-1:0]     wr_data;
   logic                            rsp_free;

   // Index of the current level
   always_comb begin
      unique case (level_ff)
         2'd0:    idx = vpn_ff[35:27];
         2'd1:    idx = vpn_ff[26:18];
         2'd2:    idx = vpn_ff[17:9];
         default: idx = vpn_ff[8:0];
      endcase
   end

   assign walk_addr = {frame_ff, idx};

   // Child frame of a present link, relative to the pool base
   assign child_off = rd_entry[ptw_pkg::ENTRY_W-1:ptw_pkg::OFFSET_W] - base_ff;

   // Entry values to write
   assign link_flags = (op_ff == ptw_pkg::OP_MAP) ? fl_ff : ptw_pkg::LINK_FLAGS_DEFAULT;
   assign link_value = {base_ff + ptw_pkg::PAGE_W'(next_free_ff), link_flags};
   assign leaf_value = (op_ff == ptw_pkg::OP_MAP)
                     ? (pa_ff | {{(ptw_pkg::ENTRY_W-ptw_pkg::OFFSET_W){1'b0}}, fl_ff})
                     : '0;

   // RAM write selection
   assign wr_en   = cmd.clear_step | cmd.link_new | cmd.leaf_write;
   assign wr_addr = cmd.clear_step ? clr_ff : walk_addr;
   always_comb begin
      priority if (cmd.clear_step) wr_data = '0;
      else if (cmd.link_new)      wr_data = link_value;
      else                        wr_data = leaf_value;
   end

   ptw_ram #(
      .WIDTH (ptw_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (walk_addr),
      .rd_data (rd_entry)
   );

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Status to the sequencer
   always_comb begin
      sts.clear_last    = (clr_ff == AW'(DEPTH - 1));
      sts.in_op_none    = (req_data.op == ptw_pkg::OP_NONE);
      sts.op_xlate      = (op_ff == ptw_pkg::OP_XLATE);
      sts.level_last    = (level_ff == 2'd3);
      sts.entry_present = rd_entry[0];
      sts.link_bad      = (child_off >= ptw_pkg::PAGE_W'(POOL_FRAMES));
      sts.pool_empty    = (next_free_ff == NW'(POOL_FRAMES));
      sts.rsp_free      = rsp_free;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         next_free_ff <= NW'(1);
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + AW'(1);
         if (cmd.link_new)   next_free_ff <= next_free_ff + NW'(1);
         if (csr_valid && csr_ready) begin
            base_ff <= csr_data[ptw_pkg::ENTRY_W-1:ptw_pkg::OFFSET_W];
         end
         if (cmd.emit)       rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Walk payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_data.op;
         vpn_ff   <= req_data.virt_addr[47:12];
         pa_ff    <= req_data.page_addr;
         fl_ff    <= req_data.flags;
         frame_ff <= '0;
         level_ff <= 2'd0;
      end else if (cmd.link_new) begin
         frame_ff <= next_free_ff[FW-1:0];
         level_ff <= level_ff + 2'd1;
      end else if (cmd.link_follow) begin
         frame_ff <= child_off[FW-1:0];
         level_ff <= level_ff + 2'd1;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_addr_ff   <= cmd.res_from_entry
                        ? {rd_entry[ptw_pkg::ENTRY_W-1:ptw_pkg::OFFSET_W],
                           {ptw_pkg::OFFSET_W{1'b0}}}
                        : '0;
      end
      if (cmd.emit) begin
         rsp_data_ff.result_addr <= res_addr_ff;
         rsp_data_ff.status      <= res_status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/four_level_page_table_walker.sv @@
// Four-level page table walker over an internal pool of table frames.
// Usage:
//   req channel (req_valid/req_stall/req_data): one word per map, unmap or
//   translate request. rsp channel (rsp_valid/rsp_stall/rsp_data): one word
//   per request, in request order. csr channel (csr_valid/csr_ready/csr_data):
//   writes the pool base address; always ready, write only while idle.
// Timing: one request at a time through the single table RAM. Each level is a
//   RAM read and an evaluate step; translate does both at all four levels,
//   map and unmap skip the evaluate step at the last level, and a
//   pool-exhausted walk ends sooner. A new request is taken only after the
//   previous one has passed its result on for output (the unused op skips
//   the walk).
// Reset (synchronous): the RAM is cleared one entry per cycle, all of its
//   POOL_FRAMES*512 entries (32768 by default); req_stall stays high meanwhile.
// Stall: a finished response waits in the output register; the walker takes
//   the next request but holds its own result until the register is free.
// Depends on ptw_pkg, ptw_ctrl, ptw_dp, ptw_ram.
module four_level_page_table_walker #(
   parameter int POOL_FRAMES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ptw_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptw_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [51:0]       csr_data
);

   ptw_pkg::cmd_type cmd;
   ptw_pkg::sts_type sts;

   // Base register takes a write in any cycle
   assign csr_ready = 1'b1;

   ptw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptw_dp #(
      .POOL_FRAMES (POOL_FRAMES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
